>>> rtl/fourier_square_wave_synth_macros.svh
// Assertion macros shared by the checker of the square wave synthesizer.
`ifndef FOURIER_SQUARE_WAVE_SYNTH_MACROS_SVH
`define FOURIER_SQUARE_WAVE_SYNTH_MACROS_SVH

// Checked at every clock edge outside reset.
`define FSWS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked at every clock edge, during reset too.
`define FSWS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

>>> rtl/fsws_pkg.sv
// Shared types, constants and tables of the square wave synthesizer.
package fsws_pkg;

  localparam int MAX_HARMONICS = 64;
  localparam int SINE_DEPTH    = 1024;
  localparam int SINE_IDX_W    = $clog2(SINE_DEPTH);
  localparam int SINE_K_W      = SINE_IDX_W + 1;

  localparam int AMP_W   = 24;
  localparam int PHASE_W = 32;
  localparam int TSTEP_W = 32;
  localparam int HCNT_W  = 7;
  localparam int IDX_W   = 16;
  localparam int TIME_W  = 48;
  localparam int SIG_W   = 26;
  localparam int SINE_W  = 16;
  localparam int COEF_W  = 24;
  localparam int PROD1_W = AMP_W + COEF_W;
  localparam int PROD2_W = PROD1_W + SINE_W;
  localparam int TERM_W  = PROD2_W - 31;
  localparam int SUM_W   = 40;
  localparam int CFG_W   = 32;

  localparam logic [63:0] Q30_ONE     = 64'd1073741824;
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

  typedef enum logic [1:0] {
    CFG_AMPLITUDE,
    CFG_PHASE_STEP,
    CFG_TIME_STEP,
    CFG_HARMONIC_COUNT
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SETUP,
    ST_ISSUE,
    ST_DRAIN
  } seq_state_e;

  typedef struct packed {
    logic              valid;
    logic [HCNT_W-1:0] j;
  } issue_t;

  typedef struct packed {
    logic              valid;
    logic              neg;
    logic [TERM_W-1:0] mag;
  } term_t;

  typedef logic [SINE_W-1:0] sine_rom_t [SINE_DEPTH+1];

  function automatic logic [SINE_W-1:0] sine_entry(input logic [63:0] k);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] t;
    logic [63:0] s;
    x  = (HALF_PI_Q30 * k) / SINE_DEPTH;
    x2 = (x * x) >> 30;
    t  = Q30_ONE - x2 / 72;
    t  = Q30_ONE - ((x2 * t) >> 30) / 42;
    t  = Q30_ONE - ((x2 * t) >> 30) / 20;
    t  = Q30_ONE - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32768) begin
      s = 64'd32768;
    end
    return s[SINE_W-1:0];
  endfunction

  function automatic sine_rom_t sine_rom_init();
    sine_rom_t rom;
    for (int k = 0; k <= SINE_DEPTH; k++) begin
      rom[k] = sine_entry(64'(k));
    end
    return rom;
  endfunction

  // Coefficient 2/(pi j) in Q24, truncated, for the odd harmonics.
  function automatic logic [COEF_W-1:0] harmonic_coef(input logic [HCNT_W-1:0] j);
    logic [COEF_W-1:0] c;
    case (j)
      7'd1:    c = 24'd10680707;
      7'd3:    c = 24'd3560235;
      7'd5:    c = 24'd2136141;
      7'd7:    c = 24'd1525815;
      7'd9:    c = 24'd1186745;
      7'd11:   c = 24'd970973;
      7'd13:   c = 24'd821592;
      7'd15:   c = 24'd712047;
      7'd17:   c = 24'd628276;
      7'd19:   c = 24'd562142;
      7'd21:   c = 24'd508605;
      7'd23:   c = 24'd464378;
      7'd25:   c = 24'd427228;
      7'd27:   c = 24'd395581;
      7'd29:   c = 24'd368300;
      7'd31:   c = 24'd344538;
      7'd33:   c = 24'd323657;
      7'd35:   c = 24'd305163;
      7'd37:   c = 24'd288667;
      7'd39:   c = 24'd273864;
      7'd41:   c = 24'd260505;
      7'd43:   c = 24'd248388;
      7'd45:   c = 24'd237349;
      7'd47:   c = 24'd227249;
      7'd49:   c = 24'd217973;
      7'd51:   c = 24'd209425;
      7'd53:   c = 24'd201522;
      7'd55:   c = 24'd194194;
      7'd57:   c = 24'd187380;
      7'd59:   c = 24'd181028;
      7'd61:   c = 24'd175093;
      7'd63:   c = 24'd169535;
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

>>> rtl/fsws_if.sv
// Valid/ready channel interfaces for sample indexes and synthesized samples.
interface fsws_in_if
  import fsws_pkg::*;
;
  logic             valid;
  logic             ready;
  logic [IDX_W-1:0] sample_index;

  modport source (output valid, output sample_index, input ready);
  modport sink (input valid, input sample_index, output ready);
endinterface

interface fsws_out_if
  import fsws_pkg::*;
;
  logic                    valid;
  logic                    ready;
  logic [TIME_W-1:0]       time_value;
  logic signed [SIG_W-1:0] signal_value;

  modport source (output valid, output time_value, output signal_value, input ready);
  modport sink (input valid, input time_value, input signal_value, output ready);
endinterface

>>> rtl/fourier_square_wave_synth.sv
// Top level of the Fourier series square wave synthesizer.
// The block takes sample indexes on in_if and returns, for each, the sample
// time and the band-limited square wave value on out_if; both channels
// transfer when valid and ready are high at a rising clock edge.
// Registers amplitude, phase step, time step and harmonic count are written
// through cfg_we_i, cfg_idx_i and cfg_data_i; the user must write them only
// while the block is idle, which the block itself does not enforce. One index
// is worked on at a time. A sequencer feeds one odd harmonic per cycle into a
// four-stage term pipeline with a shared multiply chain and a sine table, and
// the terms are summed as they leave it. The harmonic count is capped at 64.
// in_if.ready returns as the result is loaded into the output register.
// Reset clears the control state and loads the register reset values.
// When the receiver stalls, the result stays in the output register and the
// next index is not finished until that register is free.
module fourier_square_wave_synth
  import fsws_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             cfg_we_i,
  input  logic [1:0]       cfg_idx_i,
  input  logic [CFG_W-1:0] cfg_data_i,
  fsws_in_if.sink          in_if,
  fsws_out_if.source       out_if
);

  logic [AMP_W-1:0]   amp_q;
  logic [PHASE_W-1:0] pstep_q;
  logic [TSTEP_W-1:0] tstep_q;
  logic [HCNT_W-1:0]  hcnt_q;

  seq_state_e              state_q, state_d;
  logic [IDX_W-1:0]        idx_q;
  logic [PHASE_W-1:0]      phase_q;
  logic [TIME_W-1:0]       time_q;
  logic [HCNT_W-1:0]       j_q;
  logic signed [SUM_W-1:0] sum_q, sum_d;

  logic [HCNT_W-1:0] limit;
  logic              last_issue;
  logic              out_free;
  logic              load_out;
  logic              pipe_busy;
  logic              a_neg;
  logic [AMP_W-1:0]  a_mag;
  issue_t            issue;
  term_t             term;
  logic [SUM_W-1:0]  term_ext;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      amp_q   <= AMP_W'(4096);
      pstep_q <= '0;
      tstep_q <= '0;
      hcnt_q  <= HCNT_W'(1);
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_AMPLITUDE:      amp_q   <= cfg_data_i[AMP_W-1:0];
        CFG_PHASE_STEP:     pstep_q <= cfg_data_i[PHASE_W-1:0];
        CFG_TIME_STEP:      tstep_q <= cfg_data_i[TSTEP_W-1:0];
        CFG_HARMONIC_COUNT: hcnt_q  <= cfg_data_i[HCNT_W-1:0];
        default: ;
      endcase
    end
  end

  assign limit      = (hcnt_q > HCNT_W'(MAX_HARMONICS)) ? HCNT_W'(MAX_HARMONICS) : hcnt_q;
  assign last_issue = ({1'b0, j_q} + (HCNT_W+1)'(2)) > {1'b0, limit};
  assign out_free   = !out_if.valid || out_if.ready;
  assign a_neg      = amp_q[AMP_W-1];
  assign a_mag      = a_neg ? (AMP_W'(0) - amp_q) : amp_q;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_if.valid) begin
          state_d = ST_SETUP;
        end
      end
      ST_SETUP: begin
        state_d = (limit == '0) ? ST_DRAIN : ST_ISSUE;
      end
      ST_ISSUE: begin
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!pipe_busy && out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    in_if.ready = (state_q == ST_IDLE);
    issue.valid = (state_q == ST_ISSUE);
    issue.j     = j_q;
    load_out    = (state_q == ST_DRAIN) && !pipe_busy && out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign term_ext = {{(SUM_W-TERM_W){1'b0}}, term.mag};

  always_comb begin
    sum_d = sum_q;
    if (state_q == ST_SETUP) begin
      sum_d = $signed({{(SUM_W-AMP_W-7){amp_q[AMP_W-1]}}, amp_q, 7'b0});
    end else if (term.valid) begin
      sum_d = term.neg ? (sum_q - $signed(term_ext)) : (sum_q + $signed(term_ext));
    end
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sum_d;
    if (in_if.valid && in_if.ready) begin
      idx_q <= in_if.sample_index;
    end
    if (state_q == ST_SETUP) begin
      phase_q <= PHASE_W'({{(PHASE_W-IDX_W){1'b0}}, idx_q} * pstep_q);
      time_q  <= {{(TIME_W-IDX_W){1'b0}}, idx_q} * {{(TIME_W-TSTEP_W){1'b0}}, tstep_q};
      j_q     <= HCNT_W'(1);
    end else if (state_q == ST_ISSUE) begin
      j_q <= j_q + HCNT_W'(2);
    end
  end

  fsws_term_pipe u_pipe (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .issue_i (issue),
    .phase_i (phase_q),
    .a_mag_i (a_mag),
    .a_neg_i (a_neg),
    .term_o  (term),
    .busy_o  (pipe_busy)
  );

  fsws_final u_final (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .load_i   (load_out),
    .take_i   (out_if.ready),
    .sum_i    (sum_q),
    .time_i   (time_q),
    .valid_o  (out_if.valid),
    .time_o   (out_if.time_value),
    .signal_o (out_if.signal_value)
  );

endmodule

>>> rtl/fsws_sine_rom.sv
// Quarter-wave sine table with registered read data.
module fsws_sine_rom
  import fsws_pkg::*;
(
  input  logic                clk_i,
  input  logic [SINE_K_W-1:0] k_i,
  output logic [SINE_W-1:0]   sin_o
);

  localparam sine_rom_t SINE_ROM = sine_rom_init();

  logic [SINE_W-1:0] sin_q;

  always_ff @(posedge clk_i) begin
    sin_q <= SINE_ROM[k_i];
  end

  assign sin_o = sin_q;

endmodule

>>> rtl/fsws_term_pipe.sv
// Four-stage pipeline that turns one harmonic number into one signed term per cycle.
module fsws_term_pipe
  import fsws_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  issue_t             issue_i,
  input  logic [PHASE_W-1:0] phase_i,
  input  logic [AMP_W-1:0]   a_mag_i,
  input  logic               a_neg_i,
  output term_t              term_o,
  output logic               busy_o
);

  logic               v1_q, v2_q, v3_q, v4_q;
  logic [PHASE_W-1:0] hp_q;
  logic [HCNT_W-1:0]  j1_q;
  logic               neg2_q, neg3_q, neg4_q;
  logic [COEF_W-1:0]  coef2_q;
  logic [PROD1_W-1:0] p1_q;
  logic [SINE_W-1:0]  sin2;
  logic [SINE_W-1:0]  sin3_q;
  logic [TERM_W-1:0]  term_q;
  logic [SINE_IDX_W-1:0] tbl_idx;
  logic [SINE_K_W-1:0]   tbl_k;
  logic [PROD2_W-1:0]    p2;

  // Quadrants one and three read the table backwards.
  assign tbl_idx = hp_q[PHASE_W-3 -: SINE_IDX_W];
  assign tbl_k   = hp_q[PHASE_W-2] ? (SINE_K_W'(SINE_DEPTH) - {1'b0, tbl_idx})
                                   : {1'b0, tbl_idx};

  fsws_sine_rom u_rom (
    .clk_i (clk_i),
    .k_i   (tbl_k),
    .sin_o (sin2)
  );

  assign p2 = p1_q * {{(PROD2_W-SINE_W){1'b0}}, sin3_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      v4_q <= 1'b0;
    end else begin
      v1_q <= issue_i.valid;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    hp_q    <= PHASE_W'(phase_i * {{(PHASE_W-HCNT_W){1'b0}}, issue_i.j});
    j1_q    <= issue_i.j;
    neg2_q  <= hp_q[PHASE_W-1];
    coef2_q <= harmonic_coef(j1_q);
    p1_q    <= {{(PROD1_W-AMP_W){1'b0}}, a_mag_i} * {{(PROD1_W-COEF_W){1'b0}}, coef2_q};
    sin3_q  <= sin2;
    neg3_q  <= neg2_q;
    term_q  <= TERM_W'((p2 + (PROD2_W'(1) << 30)) >> 31);
    neg4_q  <= neg3_q ^ a_neg_i;
  end

  assign term_o.valid = v4_q;
  assign term_o.neg   = neg4_q;
  assign term_o.mag   = term_q;
  assign busy_o       = v1_q | v2_q | v3_q | v4_q;

endmodule

>>> rtl/fsws_final.sv
// Rounding, saturation and the output register of the synthesized samples.
module fsws_final
  import fsws_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    load_i,
  input  logic                    take_i,
  input  logic signed [SUM_W-1:0] sum_i,
  input  logic [TIME_W-1:0]       time_i,
  output logic                    valid_o,
  output logic [TIME_W-1:0]       time_o,
  output logic signed [SIG_W-1:0] signal_o
);

  localparam logic [SUM_W-1:0] POS_MAX = SUM_W'((64'd1 << (SIG_W-1)) - 64'd1);
  localparam logic [SUM_W-1:0] NEG_MAX = SUM_W'(64'd1 << (SIG_W-1));

  logic                    valid_q;
  logic [TIME_W-1:0]       time_q;
  logic signed [SIG_W-1:0] signal_q;
  logic [SUM_W-1:0]        mag;
  logic [SUM_W-1:0]        rnd;
  logic signed [SIG_W-1:0] signal_d;

  always_comb begin
    mag = sum_i[SUM_W-1] ? (SUM_W'(0) - SUM_W'(sum_i)) : SUM_W'(sum_i);
    rnd = (mag + SUM_W'(128)) >> 8;
    if (sum_i[SUM_W-1]) begin
      signal_d = (rnd > NEG_MAX) ? signed'(NEG_MAX[SIG_W-1:0])
                                 : signed'(SIG_W'(0) - rnd[SIG_W-1:0]);
    end else begin
      signal_d = (rnd > POS_MAX) ? signed'(POS_MAX[SIG_W-1:0])
                                 : signed'(rnd[SIG_W-1:0]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load_i) begin
      valid_q <= 1'b1;
    end else if (take_i) begin
      valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      time_q   <= time_i;
      signal_q <= signal_d;
    end
  end

  assign valid_o  = valid_q;
  assign time_o   = time_q;
  assign signal_o = signal_q;

endmodule

>>> rtl/fsws_checker.sv
// Port-level assertions of the square wave synthesizer and their binding.
`include "fourier_square_wave_synth_macros.svh"

module fsws_checker
  import fsws_pkg::*;
(
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [TIME_W-1:0]       time_value_i,
  input logic signed [SIG_W-1:0] signal_value_i
);

  `FSWS_ASSERT_ALWAYS(a_no_out_in_reset, !rst_ni |-> !out_valid_i, "output valid during reset")

  `FSWS_ASSERT(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i && $stable(time_value_i) && $stable(signal_value_i), "stalled result changed")

  `FSWS_ASSERT(a_busy_after_in, in_valid_i && in_ready_i |=> !in_ready_i, "ready right after an input transfer")

  `FSWS_ASSERT(a_no_instant_result, in_valid_i && in_ready_i |=> !$rose(out_valid_i), "result appeared one cycle after its input")

endmodule

bind fourier_square_wave_synth fsws_checker u_fsws_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_if.valid),
  .in_ready_i     (in_if.ready),
  .out_valid_i    (out_if.valid),
  .out_ready_i    (out_if.ready),
  .time_value_i   (out_if.time_value),
  .signal_value_i (out_if.signal_value)
);

>>> test/tb_fourier_square_wave_synth.sv
// Testbench of the square wave synthesizer: table and random stimulus checked against a predictor.
module tb_fourier_square_wave_synth;
  import fsws_pkg::*;

  logic             clk_i = 1'b0;
  logic             rst_ni = 1'b0;
  logic             cfg_we_i = 1'b0;
  logic [1:0]       cfg_idx_i = '0;
  logic [CFG_W-1:0] cfg_data_i = '0;

  fsws_in_if  in_if ();
  fsws_out_if out_if ();

  fourier_square_wave_synth dut (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_idx_i, .cfg_data_i, .in_if, .out_if
  );

  always #2 clk_i = ~clk_i;

  typedef struct {
    logic [TIME_W-1:0]       tv;
    logic signed [SIG_W-1:0] sv;
  } sample_t;

  typedef struct {
    logic [IDX_W-1:0]        idx;
    logic                    known;
    logic [TIME_W-1:0]       tv;
    logic signed [SIG_W-1:0] sv;
  } row_t;

  logic signed [AMP_W-1:0] amp_q = 24'sd4096;
  logic [PHASE_W-1:0]      pstep_q = '0;
  logic [TSTEP_W-1:0]      tstep_q = '0;
  logic [HCNT_W-1:0]       hcnt_q = 7'd1;

  sample_t pending_q[$];
  int      errors = 0;
  int      hold_off = 0;

  function automatic logic [15:0] sine_mag(input logic [63:0] k);
    logic [63:0] x, x2, t, s;
    x  = (64'd1686629713 * k) / 1024;
    x2 = (x * x) >> 30;
    t  = 64'd1073741824 - x2 / 72;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 42;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 20;
    t  = 64'd1073741824 - ((x2 * t) >> 30) / 6;
    s  = (x * t) >> 30;
    s  = (s + 64'd16384) >> 15;
    if (s > 64'd32768) s = 64'd32768;
    return s[15:0];
  endfunction

  function automatic sample_t synth_sample(input logic [IDX_W-1:0] idx);
    sample_t r;
    logic [31:0] ph, pj;
    logic [63:0] amag, k, id, c, p, term, mag;
    longint sum, val;
    int lim;
    logic neg_a, neg_s;
    ph = 32'(64'(idx) * pstep_q);
    lim = (hcnt_q > 64) ? 64 : hcnt_q;
    neg_a = amp_q < 0;
    amag = neg_a ? 64'(-longint'(amp_q)) : 64'(longint'(amp_q));
    sum = longint'(amp_q) * 128;
    for (int j = 1; j <= lim; j += 2) begin
      pj = 32'(64'(j) * ph);
      id = (64'(pj[29:0]) * 1024) >> 30;
      k = pj[30] ? 64'd1024 - id : id;
      neg_s = pj[31];
      c = 64'd10680707 / j;
      p = amag * c * 64'(sine_mag(k));
      term = (p + (64'd1 << 30)) >> 31;
      sum += (neg_a != neg_s) ? -longint'(term) : longint'(term);
    end
    mag = sum < 0 ? 64'(-sum) : 64'(sum);
    val = longint'((mag + 128) >> 8);
    if (sum < 0) val = -val;
    if (val > 33554431) val = 33554431;
    if (val < -33554432) val = -33554432;
    r.tv = 48'(64'(idx) * tstep_q);
    r.sv = val[SIG_W-1:0];
    return r;
  endfunction

  task automatic write_reg(input cfg_idx_e idx, input logic [31:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CFG_AMPLITUDE:      amp_q = data[23:0];
      CFG_PHASE_STEP:     pstep_q = data;
      CFG_TIME_STEP:      tstep_q = data;
      CFG_HARMONIC_COUNT: hcnt_q = data[6:0];
      default: ;
    endcase
  endtask

  task automatic wait_idle();
    in_if.valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
  endtask

  // Valid stays high after a transfer until a later call with a gap or wait_idle drops it.
  task automatic send_index(input logic [IDX_W-1:0] idx, input int gap);
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.sample_index <= idx;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
  endtask

  task automatic send_row(input row_t r, input int gap);
    sample_t s;
    s = synth_sample(r.idx);
    if (r.known) begin
      s.tv = r.tv;
      s.sv = r.sv;
    end
    send_index(r.idx, gap);
    pending_q.push_back(s);
  endtask

  task automatic send_random(input int n, input bit gaps);
    row_t r;
    for (int i = 0; i < n; i++) begin
      r.idx = (($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 40)));
      if ($urandom_range(0, 9) == 0) r.idx = $urandom_range(0, 1) ? 16'hFFFF : 16'h0;
      r.known = 1'b0;
      send_row(r, gaps && $urandom_range(0, 2) == 0 ? $urandom_range(0, 17) : 0);
    end
  endtask

  task automatic random_config(input bit wide);
    write_reg(CFG_AMPLITUDE, 32'($urandom));
    write_reg(CFG_PHASE_STEP, $urandom);
    write_reg(CFG_TIME_STEP, $urandom);
    write_reg(CFG_HARMONIC_COUNT, wide ? $urandom_range(0, 127) : $urandom_range(0, 12));
  endtask

  // Receiver side: random stalls per transfer, or a long hold-off when asked.
  initial begin
    sample_t e;
    int      stall;
    out_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (hold_off > 0) begin
        out_if.ready <= 1'b0;
        repeat (hold_off) @(posedge clk_i);
        hold_off = 0;
      end else begin
        stall = ($urandom_range(0, 2) == 0) ? int'($urandom_range(0, 17)) : 0;
        if (stall > 0) begin
          out_if.ready <= 1'b0;
          repeat (stall) @(posedge clk_i);
        end
      end
      out_if.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_if.valid) @(posedge clk_i);
      if (pending_q.size() == 0) begin
        $display("%0t unexpected result time %h signal %h", $time,
                 out_if.time_value, out_if.signal_value);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (e.tv !== out_if.time_value) begin
          $display("%0t time_value expected %h actual %h", $time, e.tv, out_if.time_value);
          errors++;
        end
        if (e.sv !== out_if.signal_value) begin
          $display("%0t signal_value expected %0d actual %0d", $time, e.sv,
                   out_if.signal_value);
          errors++;
        end
      end
    end
  end

  initial begin
    row_t tbl[$];
    in_if.valid = 1'b0;
    in_if.sample_index = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    // After reset: phase zero gives A/2 only, time zero.
    tbl.push_back('{16'h0000, 1'b1, 48'h0, 26'sd2048});
    tbl.push_back('{16'hFFFF, 1'b1, 48'h0, 26'sd2048});
    foreach (tbl[i]) send_row(tbl[i], i);
    wait_idle();
    write_reg(CFG_TIME_STEP, 32'hFFFFFFFF);
    write_reg(CFG_PHASE_STEP, 32'h40000000);
    write_reg(CFG_AMPLITUDE, 32'h7FFFFF);
    write_reg(CFG_HARMONIC_COUNT, 7'd64);
    tbl.delete();
    tbl.push_back('{16'hFFFF, 1'b1, 48'hFFFEFFFF0001, 26'sd0});
    for (int i = 0; i < 4; i++) tbl.push_back('{16'(i), 1'b0, '0, '0});
    foreach (tbl[i]) begin
      if (i == 0) tbl[i].sv = synth_sample(16'hFFFF).sv;
      send_row(tbl[i], 0);
    end
    wait_idle();
    // Most negative amplitude, harmonic count above the cap, then zero.
    write_reg(CFG_AMPLITUDE, 32'h800000);
    write_reg(CFG_HARMONIC_COUNT, 7'd127);
    write_reg(CFG_PHASE_STEP, 32'h01000000);
    for (int i = 0; i < 6; i++) send_row('{16'(i * 7), 1'b0, '0, '0}, 0);
    wait_idle();
    write_reg(CFG_HARMONIC_COUNT, 7'd0);
    write_reg(CFG_TIME_STEP, 32'd0);
    send_row('{16'd5, 1'b1, 48'h0, 26'sh3C00000}, 0);
    send_row('{16'hFFFF, 1'b1, 48'h0, 26'sh3C00000}, 0);
    wait_idle();
    // Long receiver hold-off while the sender keeps offering.
    hold_off = 600;
    send_random(10, 0);
    wait_idle();
    for (int ph = 0; ph < 26; ph++) begin
      random_config(ph % 5 == 0);
      send_random(50, ph % 4 != 3);
      if (ph % 6 == 0) wait_idle();
      wait_idle();
    end
    wait_idle();
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("FAIL");
    $finish;
  end
endmodule
